// ===== rtl/core/rct_pkg.sv =====
`timescale 1ns / 1ps

package rct_pkg;

  // Character codes used by the parser
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Status codes reported with message_end
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_COUNT = 2'd1;
  localparam logic [1:0] ST_BAD_ELEM  = 2'd2;
  localparam logic [1:0] ST_TRUNC     = 2'd3;

  // Configuration register indexes
  localparam logic REG_INLINE_ENABLE = 1'b0;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_ARRAY  = 4'b0010,
    MODE_INLINE = 4'b0100,
    MODE_STOP   = 4'b1000
  } mode_t;

  typedef enum logic [7:0] {
    PH_CNT     = 8'b0000_0001,
    PH_CNT_CR  = 8'b0000_0010,
    PH_DOLLAR  = 8'b0000_0100,
    PH_LEN     = 8'b0000_1000,
    PH_LEN_CR  = 8'b0001_0000,
    PH_PAYLOAD = 8'b0010_0000,
    PH_SKIP1   = 8'b0100_0000,
    PH_SKIP2   = 8'b1000_0000
  } phase_t;

  // One result beat, without run_last (implied by its place in an entry)
  typedef struct packed {
    logic [7:0] token_byte;
    logic       byte_valid;
    logic       token_end;
    logic       message_end;
    logic [1:0] parse_status;
  } res_t;

  // All results caused by one input byte
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

endpackage

// ===== rtl/core/rct_front.sv =====
`timescale 1ns / 1ps

module rct_front #(
  parameter logic [15:0] CNT_CAP = 16'hFFFF,
  parameter logic [15:0] LEN_CAP = 16'hFFFF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               inline_enable,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_message_last,
  input  logic               q_full,
  output logic               push,
  output rct_pkg::entry_t    push_entry
);

  rct_pkg::mode_t  mode_r, mode_nxt;
  rct_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] elem_r, elem_nxt;
  logic [15:0] plen_r, plen_nxt;
  logic [15:0] accum_r, accum_nxt;
  logic        seen_r, seen_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        held_vld_r, held_vld_nxt;
  logic [1:0]  sticky_r, sticky_nxt;

  logic        acc;
  logic [1:0]  n_res;
  rct_pkg::res_t res_v [2];

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  // Per-byte parse step: next state and up to two results
  always_comb begin
    logic        digit;
    logic        last;
    logic        sp;
    logic        consumed;
    logic        pbyte;
    logic [19:0] v;
    logic [1:0]  st;
    rct_pkg::res_t emt;

    mode_nxt     = mode_r;
    phase_nxt    = phase_r;
    elem_nxt     = elem_r;
    plen_nxt     = plen_r;
    accum_nxt    = accum_r;
    seen_nxt     = seen_r;
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    sticky_nxt   = sticky_r;
    n_res        = 2'd0;
    res_v[0]     = '0;
    res_v[1]     = '0;
    emt          = '0;

    last     = in_message_last;
    digit    = (in_data_byte >= rct_pkg::CH_ZERO) && (in_data_byte <= rct_pkg::CH_NINE);
    sp       = rct_pkg::is_ws(in_data_byte);
    consumed = 1'b0;
    pbyte    = 1'b0;
    st       = rct_pkg::ST_OK;
    // accum * 10 + digit value, as shifts and adds
    v = {1'b0, accum_nxt, 3'b000} + {3'b000, accum_nxt, 1'b0}
      + {16'd0, in_data_byte[3:0]};

    // First byte picks the message form
    if (mode_r == rct_pkg::MODE_IDLE) begin
      if (in_data_byte == rct_pkg::CH_STAR) begin
        mode_nxt  = rct_pkg::MODE_ARRAY;
        phase_nxt = rct_pkg::PH_CNT;
        accum_nxt = '0;
        seen_nxt  = 1'b0;
        consumed  = 1'b1;
      end else if (inline_enable) begin
        mode_nxt = rct_pkg::MODE_INLINE;
      end else begin
        sticky_nxt = rct_pkg::ST_BAD_COUNT;
        mode_nxt   = rct_pkg::MODE_STOP;
      end
    end

    if (!consumed && mode_nxt == rct_pkg::MODE_ARRAY) begin
      case (phase_nxt)
        rct_pkg::PH_CNT: begin
          if (digit) begin
            if (v > {4'd0, CNT_CAP}) begin
              sticky_nxt = rct_pkg::ST_BAD_COUNT;
              mode_nxt   = rct_pkg::MODE_STOP;
            end else begin
              accum_nxt = v[15:0];
              seen_nxt  = 1'b1;
            end
          end else if (in_data_byte == rct_pkg::CH_CR) begin
            phase_nxt = rct_pkg::PH_CNT_CR;
          end else begin
            sticky_nxt = rct_pkg::ST_BAD_COUNT;
            mode_nxt   = rct_pkg::MODE_STOP;
          end
        end
        rct_pkg::PH_CNT_CR: begin
          if (in_data_byte == rct_pkg::CH_LF && seen_nxt) begin
            elem_nxt = accum_nxt;
            if (accum_nxt == 16'd0) mode_nxt = rct_pkg::MODE_STOP;
            else phase_nxt = rct_pkg::PH_DOLLAR;
          end else begin
            sticky_nxt = rct_pkg::ST_BAD_COUNT;
            mode_nxt   = rct_pkg::MODE_STOP;
          end
        end
        rct_pkg::PH_DOLLAR: begin
          if (in_data_byte == rct_pkg::CH_DOLLAR) begin
            phase_nxt = rct_pkg::PH_LEN;
            accum_nxt = '0;
            seen_nxt  = 1'b0;
          end else begin
            sticky_nxt = rct_pkg::ST_BAD_ELEM;
            mode_nxt   = rct_pkg::MODE_STOP;
          end
        end
        rct_pkg::PH_LEN: begin
          if (digit) begin
            if (v > {4'd0, LEN_CAP}) begin
              sticky_nxt = rct_pkg::ST_BAD_ELEM;
              mode_nxt   = rct_pkg::MODE_STOP;
            end else begin
              accum_nxt = v[15:0];
              seen_nxt  = 1'b1;
            end
          end else if (in_data_byte == rct_pkg::CH_CR) begin
            phase_nxt = rct_pkg::PH_LEN_CR;
          end else begin
            sticky_nxt = rct_pkg::ST_BAD_ELEM;
            mode_nxt   = rct_pkg::MODE_STOP;
          end
        end
        rct_pkg::PH_LEN_CR: begin
          if (in_data_byte == rct_pkg::CH_LF && seen_nxt) begin
            plen_nxt = accum_nxt;
            if (accum_nxt == 16'd0) begin
              // empty token, then the element is done
              emt                 = '0;
              emt.token_end       = 1'b1;
              res_v[n_res[0]]     = emt;
              n_res               = n_res + 2'd1;
              elem_nxt            = elem_nxt - 16'd1;
              if (elem_nxt == 16'd0) mode_nxt = rct_pkg::MODE_STOP;
              else phase_nxt = rct_pkg::PH_SKIP1;
            end else begin
              phase_nxt = rct_pkg::PH_PAYLOAD;
            end
          end else begin
            sticky_nxt = rct_pkg::ST_BAD_ELEM;
            mode_nxt   = rct_pkg::MODE_STOP;
          end
        end
        rct_pkg::PH_PAYLOAD: begin
          plen_nxt            = plen_nxt - 16'd1;
          emt                 = '0;
          emt.token_byte      = in_data_byte;
          emt.byte_valid      = 1'b1;
          emt.token_end       = (plen_nxt == 16'd0) || last;
          res_v[n_res[0]]     = emt;
          n_res               = n_res + 2'd1;
          pbyte               = 1'b1;
          if (plen_nxt == 16'd0) begin
            elem_nxt = elem_nxt - 16'd1;
            if (elem_nxt == 16'd0) mode_nxt = rct_pkg::MODE_STOP;
            else phase_nxt = rct_pkg::PH_SKIP1;
          end
        end
        rct_pkg::PH_SKIP1: phase_nxt = rct_pkg::PH_SKIP2;
        rct_pkg::PH_SKIP2: phase_nxt = rct_pkg::PH_DOLLAR;
        default:           phase_nxt = rct_pkg::PH_DOLLAR;
      endcase
    end else if (!consumed && mode_nxt == rct_pkg::MODE_INLINE) begin
      // held byte is emitted once its successor shows whether it ends a token
      if (held_vld_nxt) begin
        emt             = '0;
        emt.token_byte  = held_nxt;
        emt.byte_valid  = 1'b1;
        emt.token_end   = sp;
        res_v[n_res[0]] = emt;
        n_res           = n_res + 2'd1;
        held_vld_nxt    = 1'b0;
      end
      if (!sp) begin
        if (last) begin
          emt             = '0;
          emt.token_byte  = in_data_byte;
          emt.byte_valid  = 1'b1;
          emt.token_end   = 1'b1;
          res_v[n_res[0]] = emt;
          n_res           = n_res + 2'd1;
        end else begin
          held_nxt     = in_data_byte;
          held_vld_nxt = 1'b1;
        end
      end
    end

    // Message close: status, truncated token, bare result, state back to reset
    if (last) begin
      st = sticky_nxt;
      if (mode_nxt == rct_pkg::MODE_ARRAY) begin
        if (phase_nxt == rct_pkg::PH_CNT || phase_nxt == rct_pkg::PH_CNT_CR) begin
          st = rct_pkg::ST_BAD_COUNT;
        end else begin
          if (phase_nxt == rct_pkg::PH_PAYLOAD && !pbyte) begin
            emt             = '0;
            emt.token_end   = 1'b1;
            res_v[n_res[0]] = emt;
            n_res           = n_res + 2'd1;
          end
          st = rct_pkg::ST_TRUNC;
        end
      end else if (mode_nxt == rct_pkg::MODE_INLINE) begin
        st = rct_pkg::ST_OK;
      end
      if (n_res == 2'd0) begin
        res_v[0] = '0;
        n_res    = 2'd1;
      end
      if (n_res == 2'd2) begin
        res_v[1].message_end  = 1'b1;
        res_v[1].parse_status = st;
      end else begin
        res_v[0].message_end  = 1'b1;
        res_v[0].parse_status = st;
      end
      mode_nxt     = rct_pkg::MODE_IDLE;
      phase_nxt    = rct_pkg::PH_CNT;
      elem_nxt     = '0;
      plen_nxt     = '0;
      accum_nxt    = '0;
      seen_nxt     = 1'b0;
      held_nxt     = '0;
      held_vld_nxt = 1'b0;
      sticky_nxt   = rct_pkg::ST_OK;
    end
  end

  // Queue push: one entry per byte that yields results
  assign push          = acc && (n_res != 2'd0);
  assign push_entry.two = (n_res == 2'd2);
  assign push_entry.r0 = res_v[0];
  assign push_entry.r1 = res_v[1];

  // Parser state advances only on accepted beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= rct_pkg::MODE_IDLE;
      phase_r    <= rct_pkg::PH_CNT;
      elem_r     <= '0;
      plen_r     <= '0;
      accum_r    <= '0;
      seen_r     <= 1'b0;
      held_r     <= '0;
      held_vld_r <= 1'b0;
      sticky_r   <= rct_pkg::ST_OK;
    end else if (acc) begin
      mode_r     <= mode_nxt;
      phase_r    <= phase_nxt;
      elem_r     <= elem_nxt;
      plen_r     <= plen_nxt;
      accum_r    <= accum_nxt;
      seen_r     <= seen_nxt;
      held_r     <= held_nxt;
      held_vld_r <= held_vld_nxt;
      sticky_r   <= sticky_nxt;
    end
  end

endmodule

// ===== rtl/core/rct_queue.sv =====
`timescale 1ns / 1ps

module rct_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rct_pkg::entry_t push_entry,
  input  logic            pop,
  output rct_pkg::entry_t head,
  output logic            full,
  output logic            empty
);

  localparam int PTR_W = (rct_pkg::QUEUE_DEPTH > 1) ? $clog2(rct_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(rct_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(rct_pkg::QUEUE_DEPTH - 1);

  rct_pkg::entry_t slot_r [rct_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(rct_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + CNT_W'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CNT_W'(1);
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_entry;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/rct_back.sv =====
`timescale 1ns / 1ps

module rct_back (
  input  logic            clk,
  input  logic            rst_n,
  input  rct_pkg::entry_t head,
  input  logic            q_empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_token_byte,
  output logic            out_byte_valid,
  output logic            out_token_end,
  output logic            out_message_end,
  output logic [1:0]      out_parse_status,
  output logic            out_run_last
);

  logic          out_valid_r;
  rct_pkg::res_t out_res_r;
  logic          out_run_r;
  logic          sel_r, sel_nxt;
  logic          load, take, last_of;
  rct_pkg::res_t cur;

  // Output register free or draining this cycle
  assign load    = !out_valid_r || out_ready;
  assign take    = load && !q_empty;
  assign cur     = sel_r ? head.r1 : head.r0;
  assign last_of = sel_r || !head.two;

  // Walk the one or two results of the head entry
  always_comb begin
    pop     = 1'b0;
    sel_nxt = sel_r;
    if (take) begin
      pop     = last_of;
      sel_nxt = !last_of;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      if (load) out_valid_r <= !q_empty;
      sel_r <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res_r <= cur;
      out_run_r <= last_of;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_token_byte   = out_res_r.token_byte;
  assign out_byte_valid   = out_res_r.byte_valid;
  assign out_token_end    = out_res_r.token_end;
  assign out_message_end  = out_res_r.message_end;
  assign out_parse_status = out_res_r.parse_status;
  assign out_run_last     = out_run_r;

endmodule

// ===== rtl/core/resp_command_tokenizer.sv =====
`timescale 1ns / 1ps
// Byte-serial command tokenizer.
// Input channel (in_valid/in_ready): one message byte per beat, with
// in_message_last on the final byte of each message. A message starting
// with '*' is parsed as an array of bulk strings; any other message is split
// on whitespace when the inline_enable register (address 0) is set.
// Output channel (out_valid/out_ready): one token byte per beat, with
// token_end, message_end, parse_status and run_last (last beat caused by an
// input byte). An input byte gives zero, one or two output beats.
// A beat caused by an accepted byte is registered in the queue and then in
// the output register before it is presented. Input throughput is one byte
// per cycle while the queue is not full; the output register drains one
// beat per cycle while out_ready is high, so a byte giving two beats needs
// an extra beat, absorbed by the four-entry queue between parser and output.
// When the receiver stalls, the queue fills and in_ready drops once it holds
// four entries. Reset clears parser state, empties the queue, clears out_valid
// and sets inline_enable to 1; no clearing pass is needed.
// Configuration is APB: writes take setup and access cycles, pready is tied
// high, and registers should only be written while the block is idle.

module resp_command_tokenizer #(
  parameter longint unsigned MAX_ELEMENTS = 65535,
  parameter longint unsigned MAX_BULK_LEN = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_message_last,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_token_byte,
  output logic        out_byte_valid,
  output logic        out_token_end,
  output logic        out_message_end,
  output logic [1:0]  out_parse_status,
  output logic        out_run_last,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [15:0] CNT_CAP = (MAX_ELEMENTS < 65535) ? 16'(MAX_ELEMENTS) : 16'hFFFF;
  localparam logic [15:0] LEN_CAP = (MAX_BULK_LEN < 65535) ? 16'(MAX_BULK_LEN) : 16'hFFFF;

  logic            inline_en_r;
  logic            cfg_wr;
  logic            push, pop, q_full, q_empty;
  rct_pkg::entry_t push_entry, head;

  // Register file: one bit at index 0
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inline_en_r <= 1'b1;
    end else if (cfg_wr && paddr[2] == rct_pkg::REG_INLINE_ENABLE) begin
      inline_en_r <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == rct_pkg::REG_INLINE_ENABLE) ? {31'd0, inline_en_r} : 32'd0;

  rct_front #(
    .CNT_CAP (CNT_CAP),
    .LEN_CAP (LEN_CAP)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .inline_enable   (inline_en_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_message_last (in_message_last),
    .q_full          (q_full),
    .push            (push),
    .push_entry      (push_entry)
  );

  rct_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  rct_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_empty          (q_empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_byte   (out_token_byte),
    .out_byte_valid   (out_byte_valid),
    .out_token_end    (out_token_end),
    .out_message_end  (out_message_end),
    .out_parse_status (out_parse_status),
    .out_run_last     (out_run_last)
  );

endmodule

// ===== rtl/core/rct_checker.sv =====
`timescale 1ns / 1ps

module rct_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_byte_valid,
  input logic       out_token_end,
  input logic       out_message_end,
  input logic [1:0] out_parse_status,
  input logic       out_run_last
);

  // Output beat is held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  // Nothing is presented right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Message end is always the last beat of its input byte
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_message_end |-> out_run_last)
    else $error("message_end without run_last");

  // Status only travels with message_end
  a_status_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_message_end |-> out_parse_status == rct_pkg::ST_OK)
    else $error("status on a beat that is not message end");

  // A beat without a byte and without message_end is an empty token
  a_empty_token: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid && !out_message_end |-> out_token_end)
    else $error("byteless beat that ends nothing");

endmodule

bind resp_command_tokenizer rct_checker u_rct_checker (.*);
